### hw/rtl/rdag_pkg.sv
// Package for the raster downsample address generator.
// Holds field widths, register indexes, divider lane types and the divider step.
// No dependencies.
package rdag_pkg;

  localparam int DIM_BITS   = 16;
  localparam int LAYER_BITS = 8;
  localparam int ADDR_BITS  = 48;
  localparam int NUM_BITS   = 2 * DIM_BITS + 1;
  localparam int DEN_BITS   = DIM_BITS + 1;
  localparam int REG_BITS   = 3;

  localparam logic [REG_BITS-1:0] REG_SRC_ROWS       = 3'd0;
  localparam logic [REG_BITS-1:0] REG_SRC_COLS       = 3'd1;
  localparam logic [REG_BITS-1:0] REG_SAMP_ROWS      = 3'd2;
  localparam logic [REG_BITS-1:0] REG_SAMP_COLS      = 3'd3;
  localparam logic [REG_BITS-1:0] REG_WIN_ROW_OFFSET = 3'd4;
  localparam logic [REG_BITS-1:0] REG_WIN_COL_OFFSET = 3'd5;
  localparam logic [REG_BITS-1:0] REG_FULL_COLS      = 3'd6;
  localparam logic [REG_BITS-1:0] REG_FULL_ROWS      = 3'd7;

  typedef struct packed {
    logic [DEN_BITS-1:0] rem;
    logic [DIM_BITS-1:0] low;
  } div_lane_t;

  typedef struct packed {
    logic                  bad;
    logic [LAYER_BITS-1:0] layer;
    div_lane_t             row;
    div_lane_t             col;
  } div_stage_t;

  // one restoring step: shift in the next numerator bit, subtract 2*samp if it fits
  function automatic div_lane_t div_step(div_lane_t lane, logic [DIM_BITS-1:0] samp);
    logic [DEN_BITS:0] den;
    logic [DEN_BITS:0] shifted;
    logic [DEN_BITS:0] trial;
    logic              fits;
    div_lane_t         res;
    den     = {1'b0, samp, 1'b0};
    shifted = {lane.rem, lane.low[DIM_BITS-1]};
    trial   = shifted - den;
    fits    = (shifted >= den);
    res.rem = fits ? trial[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
    res.low = {lane.low[DIM_BITS-2:0], fits};
    return res;
  endfunction

endpackage

### hw/rtl/raster_downsample_address_gen.sv
// Top level of the raster downsample address generator.
// Uses rdag_pkg for widths, register indexes and the divider step.
// Holds the configuration registers and the full address pipeline.

// Takes one beat per cycle unless every stage is full and the output side stalls,
// and returns one beat per request, in order. The pipeline depth is set by the
// source row and column division, done as two parallel restoring dividers with
// one quotient bit per pipeline stage; one stage forms the numerators, one stage
// does the stride and plane multiplies, and one stage adds the terms into the
// output register. Every stage holds its beat while the stage ahead is full and
// stalled, so empty stages fill even while the output waits. Write configuration
// only while the block is idle; the plane size is a registered product, updated
// in the cycle after a write to full_cols or full_rows.
module raster_downsample_address_gen (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rdag_pkg::REG_BITS-1:0]    cfg_idx_i,
  input  logic [rdag_pkg::DIM_BITS-1:0]    cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rdag_pkg::LAYER_BITS-1:0]  layer_i,
  input  logic [rdag_pkg::DIM_BITS-1:0]    out_row_i,
  input  logic [rdag_pkg::DIM_BITS-1:0]    out_col_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rdag_pkg::ADDR_BITS-1:0]   cell_address_o,
  output logic                             bad_request_o
);

  localparam int DIM      = rdag_pkg::DIM_BITS;
  localparam int LAYER    = rdag_pkg::LAYER_BITS;
  localparam int ADDR     = rdag_pkg::ADDR_BITS;
  localparam int NSTG     = DIM + 3;
  localparam int PROD_STG = DIM + 1;
  localparam int OUT_STG  = DIM + 2;
  localparam int PLANE_W  = 2 * DIM;
  localparam int LTERM_W  = LAYER + 2 * DIM;
  localparam int RTERM_W  = 2 * DIM + 1;

  logic [DIM-1:0] src_rows_q, src_cols_q, samp_rows_q, samp_cols_q;
  logic [DIM-1:0] win_row_offset_q, win_col_offset_q, full_cols_q, full_rows_q;
  logic [PLANE_W-1:0] plane_q;

  logic [NSTG-1:0] vld_q, vld_d, en;

  rdag_pkg::div_stage_t pipe_q [0:DIM];
  rdag_pkg::div_stage_t pipe_d [0:DIM];

  logic [rdag_pkg::NUM_BITS-1:0] num_row, num_col;

  logic [DIM:0]         row_sum;
  logic [LTERM_W-1:0]   layer_term_d, layer_term_q;
  logic [RTERM_W-1:0]   row_term_d, row_term_q;
  logic [DIM:0]         col_sum_d, col_sum_q;
  logic                 prod_bad_q;

  logic [ADDR-1:0]      addr_sum;
  logic [ADDR-1:0]      cell_address_q;
  logic                 bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rows_q       <= DIM'(1);
      src_cols_q       <= DIM'(1);
      samp_rows_q      <= DIM'(1);
      samp_cols_q      <= DIM'(1);
      win_row_offset_q <= '0;
      win_col_offset_q <= '0;
      full_cols_q      <= DIM'(1);
      full_rows_q      <= DIM'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rdag_pkg::REG_SRC_ROWS:       src_rows_q       <= cfg_wdata_i;
        rdag_pkg::REG_SRC_COLS:       src_cols_q       <= cfg_wdata_i;
        rdag_pkg::REG_SAMP_ROWS:      samp_rows_q      <= cfg_wdata_i;
        rdag_pkg::REG_SAMP_COLS:      samp_cols_q      <= cfg_wdata_i;
        rdag_pkg::REG_WIN_ROW_OFFSET: win_row_offset_q <= cfg_wdata_i;
        rdag_pkg::REG_WIN_COL_OFFSET: win_col_offset_q <= cfg_wdata_i;
        rdag_pkg::REG_FULL_COLS:      full_cols_q      <= cfg_wdata_i;
        rdag_pkg::REG_FULL_ROWS:      full_rows_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    plane_q <= full_cols_q * full_rows_q;
  end

  // stage enables: advance when empty or when the stage ahead advances
  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = in_valid_i;
    for (int k = 1; k < NSTG; k++) begin
      vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign num_row = {out_row_i, 1'b1} * src_rows_q;
  assign num_col = {out_col_i, 1'b1} * src_cols_q;

  always_comb begin
    pipe_d[0].bad     = (out_row_i >= samp_rows_q) || (out_col_i >= samp_cols_q);
    pipe_d[0].layer   = layer_i;
    pipe_d[0].row.rem = num_row[rdag_pkg::NUM_BITS-1:DIM];
    pipe_d[0].row.low = num_row[DIM-1:0];
    pipe_d[0].col.rem = num_col[rdag_pkg::NUM_BITS-1:DIM];
    pipe_d[0].col.low = num_col[DIM-1:0];
    for (int k = 1; k <= DIM; k++) begin
      pipe_d[k].bad   = pipe_q[k-1].bad;
      pipe_d[k].layer = pipe_q[k-1].layer;
      pipe_d[k].row   = rdag_pkg::div_step(pipe_q[k-1].row, samp_rows_q);
      pipe_d[k].col   = rdag_pkg::div_step(pipe_q[k-1].col, samp_cols_q);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= DIM; k++) begin
      if (en[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  always_comb begin
    row_sum      = {1'b0, pipe_q[DIM].row.low} + {1'b0, win_row_offset_q};
    row_term_d   = row_sum * full_cols_q;
    layer_term_d = pipe_q[DIM].layer * plane_q;
    col_sum_d    = {1'b0, pipe_q[DIM].col.low} + {1'b0, win_col_offset_q};
  end

  always_ff @(posedge clk_i) begin
    if (en[PROD_STG]) begin
      layer_term_q <= layer_term_d;
      row_term_q   <= row_term_d;
      col_sum_q    <= col_sum_d;
      prod_bad_q   <= pipe_q[DIM].bad;
    end
  end

  assign addr_sum = ADDR'(layer_term_q) + ADDR'(row_term_q) + ADDR'(col_sum_q);

  always_ff @(posedge clk_i) begin
    if (en[OUT_STG]) begin
      cell_address_q <= prod_bad_q ? '0 : addr_sum;
      bad_q          <= prod_bad_q;
    end
  end

  assign in_ready_o     = en[0];
  assign out_valid_o    = vld_q[OUT_STG];
  assign cell_address_o = cell_address_q;
  assign bad_request_o  = bad_q;

  a_bad_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_request_o |-> cell_address_o == '0)
    else $error("rejected beat carries a nonzero address");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $countones(vld_q) == NSTG && !out_ready_i)
    else $error("input blocked while the pipeline has room");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted beat not held in the first stage");

endmodule
